[rtl/utf8d_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

    // One decoded character as it leaves the block
    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  seq_length;
    } t_result;

    // Lead byte ranges
    localparam logic [7:0] LEAD2_LO  = 8'hC0;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_END = 8'hF5;

    // Sequence lengths
    localparam logic [2:0] LEN_1 = 3'd1;
    localparam logic [2:0] LEN_2 = 3'd2;
    localparam logic [2:0] LEN_3 = 3'd3;
    localparam logic [2:0] LEN_4 = 3'd4;

endpackage

`default_nettype wire

[rtl/utf8d_decode.sv]
`timescale 1ns / 1ps
`default_nettype none

module utf8d_decode
    import utf8d_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic       i_stall,
    input  wire logic [7:0] i_byte_in,
    output logic            o_valid,
    output t_result         o_word
);

    logic [20:0] r_partial, n_partial;
    logic [1:0]  r_remaining, n_remaining;
    logic [2:0]  r_size, n_size;
    logic        w_take;

    assign w_take = i_valid && !i_stall;

    // Next state and result for the incoming byte
    always_comb begin
        n_partial   = r_partial;
        n_remaining = r_remaining;
        n_size      = r_size;
        o_valid     = 1'b0;
        o_word      = '{code_point: {13'd0, i_byte_in}, seq_length: LEN_1};
        if (r_remaining != 2'd0) begin
            // following byte: shift in its low six bits, top bits unchecked
            n_partial   = {r_partial[14:0], i_byte_in[5:0]};
            n_remaining = r_remaining - 2'd1;
            o_valid     = w_take && (r_remaining == 2'd1);
            o_word      = '{code_point: n_partial, seq_length: r_size};
        end else begin
            priority if (i_byte_in >= LEAD2_LO && i_byte_in < LEAD3_LO) begin
                n_partial   = {16'd0, i_byte_in[4:0]};
                n_remaining = 2'd1;
                n_size      = LEN_2;
            end else if (i_byte_in >= LEAD3_LO && i_byte_in < LEAD4_LO) begin
                n_partial   = {17'd0, i_byte_in[3:0]};
                n_remaining = 2'd2;
                n_size      = LEN_3;
            end else if (i_byte_in >= LEAD4_LO && i_byte_in < LEAD4_END) begin
                n_partial   = {18'd0, i_byte_in[2:0]};
                n_remaining = 2'd3;
                n_size      = LEN_4;
            end else begin
                // ASCII or stray byte goes straight out as its own value
                o_valid = w_take;
            end
        end
    end

    // Sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial   <= '0;
            r_remaining <= '0;
            r_size      <= '0;
        end else if (w_take) begin
            r_partial   <= n_partial;
            r_remaining <= n_remaining;
            r_size      <= n_size;
        end
    end

endmodule

`default_nettype wire

[rtl/utf8d_skid.sv]
`timescale 1ns / 1ps
`default_nettype none

module utf8d_skid
    import utf8d_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_word,
    output logic         o_stall,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_word
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;

    // Output register plus one skid word; upstream stalls only when skid is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
                r_out       <= i_word;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
            r_skid       <= i_word;
        end
    end

    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule

`default_nettype wire

[rtl/utf8_byte_stream_decoder.sv]
// Each result is decoded combinationally and registered in the output stage.
// Throughput: one byte per cycle while o_in_stall is low; the sequence state updates with
// a single shift-and-or. A two-word output stage (result register plus skid word) keeps
// input flowing while the skid word is free; o_in_stall rises only when both words are held.
// Reset (synchronous, active low) clears the open sequence and empties the output stage.
`timescale 1ns / 1ps
`default_nettype none

module utf8_byte_stream_decoder
    import utf8d_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_byte_in,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [20:0]      o_code_point,
    output logic [2:0]       o_seq_length
);

    logic    w_dec_valid;
    t_result w_dec_word;
    t_result w_out_word;

    utf8d_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_stall   (o_in_stall),
        .i_byte_in (i_byte_in),
        .o_valid   (w_dec_valid),
        .o_word    (w_dec_word)
    );

    utf8d_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dec_valid),
        .i_word  (w_dec_word),
        .o_stall (o_in_stall),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (w_out_word)
    );

    assign o_code_point = w_out_word.code_point;
    assign o_seq_length = w_out_word.seq_length;

    // Skid word is only ever occupied behind a held result
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");

    // Length always one to four
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_seq_length != 3'd0 && o_seq_length <= LEN_4))
        else $error("sequence length out of range");

    // Single-byte results carry only the byte itself
    a_len1_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_seq_length == LEN_1) |-> (o_code_point[20:8] == 13'd0))
        else $error("one-byte result wider than a byte");

    // Two-byte results fit in eleven bits
    a_len2_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_seq_length == LEN_2) |-> (o_code_point[20:11] == 10'd0))
        else $error("two-byte result wider than eleven bits");

endmodule

`default_nettype wire
